// ===== src/spq_pkg.sv =====
// Shared constants, register codes and controller/datapath interface types
// for the scale pitch quantiser. No dependencies.
`default_nettype none

package spq_pkg;

    // Default build parameters
    localparam int MAX_SCALE_LEN_DEF = 12;
    localparam int OCTAVE_SPAN_DEF   = 8;

    // Field widths
    localparam int NOTE_W  = 7;
    localparam int OCTS_W  = 5;
    localparam int LEN_W   = 4;
    localparam int STEPS_W = 48;
    localparam int STEP_W  = 4;
    localparam int DEG_W   = 8;
    localparam int OCT_W   = 6;
    localparam int CFGI_W  = 4;

    // Internal widths
    localparam int SPAN_W  = 7;   // span * length, up to 96 with defaults
    localparam int DEGO_W  = 5;   // degree octave, within +/- span
    localparam int OSUM_W  = 7;   // octave shift plus degree octave
    localparam int CAND_W  = 11;  // unclamped candidate note

    localparam int SEMIS_PER_OCTAVE = 12;
    localparam int MIDI_TOP         = 127;

    // Configuration register indices
    localparam logic [CFGI_W-1:0] CFG_ROOT_NOTE    = 4'd0;
    localparam logic [CFGI_W-1:0] CFG_OCTAVE_SHIFT = 4'd1;
    localparam logic [CFGI_W-1:0] CFG_SCALE_LENGTH = 4'd2;
    localparam logic [CFGI_W-1:0] CFG_SCALE_STEPS  = 4'd3;

    // Register reset values
    localparam logic [NOTE_W-1:0]  ROOT_RST  = 7'd60;
    localparam logic [OCTS_W-1:0]  OCTS_RST  = 5'd0;
    localparam logic [LEN_W-1:0]   LEN_RST   = 4'd7;
    localparam logic [STEPS_W-1:0] STEPS_RST = 48'h0000_0B97_5420;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // capture input note, set up the degree walk
        logic step;      // evaluate current degree and advance
        logic load_out;  // move the winner into the result register
    } spq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;      // current degree is the top of the walk
    } spq_sts_t;

endpackage

`default_nettype wire

// ===== src/scale_pitch_quantizer.sv =====
// Top level of the scale pitch quantiser: ties the controller to the datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | s_valid / s_ready    | s_note_in
//  result   | m_valid / m_ready    | m_snapped_note, m_scale_degree, m_note_octave
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One degree is evaluated per cycle by a single candidate/compare unit, which walks
// every degree from -OCTAVE_SPAN*len to +OCTAVE_SPAN*len; the next note is accepted
// only once that walk is over.
// A finished result sits in the output register while the next note is taken;
// the last degree holds until that register is free.
// Synchronous active-low reset restores the configuration reset values.
`default_nettype none

module scale_pitch_quantizer
    import spq_pkg::*;
#(
    parameter int MAX_SCALE_LEN = MAX_SCALE_LEN_DEF,
    parameter int OCTAVE_SPAN   = OCTAVE_SPAN_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [NOTE_W-1:0]  s_note_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [NOTE_W-1:0]       m_snapped_note,
    output logic signed [DEG_W-1:0] m_scale_degree,
    output logic signed [OCT_W-1:0] m_note_octave,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFGI_W-1:0]  cfg_index,
    input  wire logic [STEPS_W-1:0] cfg_data
);

    spq_cmd_t cmd;
    spq_sts_t sts;

    // Configuration beats are always taken
    assign cfg_ready = 1'b1;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    spq_datapath #(
        .MAX_SCALE_LEN (MAX_SCALE_LEN),
        .OCTAVE_SPAN   (OCTAVE_SPAN)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .note_in      (s_note_in),
        .cmd          (cmd),
        .sts          (sts),
        .snapped_note (m_snapped_note),
        .scale_degree (m_scale_degree),
        .note_octave  (m_note_octave)
    );

endmodule

`default_nettype wire

// ===== src/spq_ctrl.sv =====
// Controller for the scale pitch quantiser: handshakes and degree-walk sequencing.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output spq_cmd_t      cmd,
    input  wire spq_sts_t sts
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Sequencing: the final degree waits until the result register is free
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!sts.last) begin
                    cmd.step = 1'b1;
                end else if (out_free) begin
                    cmd.step     = 1'b1;
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/spq_datapath.sv =====
// Datapath for the scale pitch quantiser: configuration registers, degree
// counters, candidate note, best-so-far tracking and result register. Depends on spq_pkg.
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int MAX_SCALE_LEN = MAX_SCALE_LEN_DEF,
    parameter int OCTAVE_SPAN   = OCTAVE_SPAN_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr,
    input  wire logic [CFGI_W-1:0]  cfg_index,
    input  wire logic [STEPS_W-1:0] cfg_data,
    input  wire logic [NOTE_W-1:0]  note_in,
    input  wire spq_cmd_t           cmd,
    output spq_sts_t                sts,
    output logic [NOTE_W-1:0]       snapped_note,
    output logic signed [DEG_W-1:0] scale_degree,
    output logic signed [OCT_W-1:0] note_octave
);

    localparam int IDX_W = (MAX_SCALE_LEN > 1) ? $clog2(MAX_SCALE_LEN) : 1;

    // Configuration registers
    logic [NOTE_W-1:0]        root_reg;
    logic signed [OCTS_W-1:0] octs_reg;
    logic [LEN_W-1:0]         len_cfg_reg;
    logic [STEPS_W-1:0]       steps_reg;

    // Walk state
    logic [NOTE_W-1:0]        target_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [SPAN_W-1:0]        span_reg;
    logic signed [DEG_W-1:0]  deg_reg;
    logic [IDX_W-1:0]         wrap_reg;
    logic signed [DEGO_W-1:0] dego_reg;
    logic                     have_reg;

    // Best candidate so far
    logic [NOTE_W-1:0]        best_note_reg;
    logic [NOTE_W-1:0]        best_dist_reg;
    logic signed [DEG_W-1:0]  best_deg_reg;
    logic signed [OCT_W-1:0]  best_oct_reg;

    // Result register
    logic [NOTE_W-1:0]        out_note_reg;
    logic signed [DEG_W-1:0]  out_deg_reg;
    logic signed [OCT_W-1:0]  out_oct_reg;

    logic [LEN_W-1:0]         len_eff;
    logic [SPAN_W-1:0]        span_eff;
    logic [STEP_W-1:0]        step_val;
    logic signed [OSUM_W-1:0] oct_sum;
    logic signed [CAND_W-1:0] oct_wide;
    logic signed [CAND_W-1:0] cand_raw;
    logic [NOTE_W-1:0]        cand;
    logic [NOTE_W-1:0]        note_gap;
    logic                     take;
    logic                     wrap_end;
    logic [NOTE_W-1:0]        sel_note;
    logic [NOTE_W-1:0]        sel_dist;
    logic signed [DEG_W-1:0]  sel_deg;
    logic signed [OCT_W-1:0]  sel_oct;

    // Configuration writes; unknown indices are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg    <= ROOT_RST;
            octs_reg    <= OCTS_RST;
            len_cfg_reg <= LEN_RST;
            steps_reg   <= STEPS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_ROOT_NOTE:    root_reg    <= cfg_data[NOTE_W-1:0];
                CFG_OCTAVE_SHIFT: octs_reg    <= cfg_data[OCTS_W-1:0];
                CFG_SCALE_LENGTH: len_cfg_reg <= cfg_data[LEN_W-1:0];
                CFG_SCALE_STEPS:  steps_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective length: zero reads as one, saturates at the table size
    always_comb begin
        priority if (len_cfg_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_cfg_reg > LEN_W'(MAX_SCALE_LEN)) begin
            len_eff = LEN_W'(MAX_SCALE_LEN);
        end else begin
            len_eff = len_cfg_reg;
        end
    end

    assign span_eff = SPAN_W'(OCTAVE_SPAN) * SPAN_W'(len_eff);

    // Candidate note for the current degree
    assign step_val = steps_reg[{wrap_reg, 2'b00} +: STEP_W];
    assign oct_sum  = OSUM_W'(octs_reg) + OSUM_W'(dego_reg);
    assign oct_wide = CAND_W'(oct_sum);
    assign cand_raw = $signed({{(CAND_W-NOTE_W){1'b0}}, root_reg})
                    + $signed({{(CAND_W-STEP_W){1'b0}}, step_val})
                    + (oct_wide <<< 3) + (oct_wide <<< 2);

    always_comb begin
        priority if (cand_raw < 0) begin
            cand = '0;
        end else if (cand_raw > CAND_W'(MIDI_TOP)) begin
            cand = NOTE_W'(MIDI_TOP);
        end else begin
            cand = cand_raw[NOTE_W-1:0];
        end
    end

    assign note_gap = (cand > target_reg) ? (cand - target_reg) : (target_reg - cand);

    // Nearest wins, then the lower note, then the earlier degree
    assign take = !have_reg || (note_gap < best_dist_reg)
               || ((note_gap == best_dist_reg) && (cand < best_note_reg));

    assign sel_note = take ? cand : best_note_reg;
    assign sel_dist = take ? note_gap : best_dist_reg;
    assign sel_deg  = take ? deg_reg : best_deg_reg;
    assign sel_oct  = take ? oct_sum[OCT_W-1:0] : best_oct_reg;

    assign wrap_end = (LEN_W'(wrap_reg) == (len_reg - LEN_W'(1)));
    assign sts.last = (deg_reg == $signed({1'b0, span_reg}));

    // Degree walk and best tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (cmd.start) begin
            have_reg <= 1'b0;
        end else if (cmd.step) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            target_reg <= note_in;
            len_reg    <= len_eff;
            span_reg   <= span_eff;
            deg_reg    <= DEG_W'(0) - DEG_W'(span_eff);
            wrap_reg   <= '0;
            dego_reg   <= DEGO_W'(-OCTAVE_SPAN);
        end else if (cmd.step) begin
            best_note_reg <= sel_note;
            best_dist_reg <= sel_dist;
            best_deg_reg  <= sel_deg;
            best_oct_reg  <= sel_oct;
            deg_reg       <= deg_reg + DEG_W'(1);
            if (wrap_end) begin
                wrap_reg <= '0;
                dego_reg <= dego_reg + DEGO_W'(1);
            end else begin
                wrap_reg <= wrap_reg + IDX_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_note_reg <= sel_note;
            out_deg_reg  <= sel_deg;
            out_oct_reg  <= sel_oct;
        end
    end

    assign snapped_note = out_note_reg;
    assign scale_degree = out_deg_reg;
    assign note_octave  = out_oct_reg;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for scale_pitch_quantizer: drives notes and register
// writes, predicts every snapped result and compares it. Depends on spq_pkg.
`default_nettype none

module testbench;
    import spq_pkg::*;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // Block ports
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic [NOTE_W-1:0]       s_note_in = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic [NOTE_W-1:0]       m_snapped_note;
    logic signed [DEG_W-1:0] m_scale_degree;
    logic signed [OCT_W-1:0] m_note_octave;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFGI_W-1:0]       cfg_index = '0;
    logic [STEPS_W-1:0]      cfg_data  = '0;

    scale_pitch_quantizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_note_in      (s_note_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_snapped_note (m_snapped_note),
        .m_scale_degree (m_scale_degree),
        .m_note_octave  (m_note_octave),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // One expected result, with the note that caused it for messages
    typedef struct packed {
        logic [NOTE_W-1:0]       note_in;
        logic [NOTE_W-1:0]       snapped;
        logic signed [DEG_W-1:0] degree;
        logic signed [OCT_W-1:0] octave;
    } snap_t;

    snap_t pending_snaps[$];
    int    error_count       = 0;
    int    long_hold_cycles  = 0;

    // Local copy of the configuration registers
    logic [NOTE_W-1:0]         root_mirror  = ROOT_RST;
    logic signed [OCTS_W-1:0]  shift_mirror = OCTS_RST;
    logic [LEN_W-1:0]          len_mirror   = LEN_RST;
    logic [STEPS_W-1:0]        steps_mirror = STEPS_RST;

    // Nearest scale note: walk every degree, lower note wins a tie,
    // earliest degree wins equal notes
    function automatic snap_t predict_snap(input logic [NOTE_W-1:0] note);
        snap_t r;
        int    len, d, wrapped, dego, step_val, oct, cand, diff, best_diff, target;
        bit    have;
        r         = '0;
        r.note_in = note;
        target    = int'(note);
        have      = 1'b0;
        best_diff = 0;
        len       = int'(len_mirror);
        if (len < 1) len = 1;
        if (len > MAX_SCALE_LEN_DEF) len = MAX_SCALE_LEN_DEF;
        for (d = -OCTAVE_SPAN_DEF * len; d <= OCTAVE_SPAN_DEF * len; d++) begin
            wrapped  = ((d % len) + len) % len;
            dego     = (d >= 0) ? d / len : -((-d + len - 1) / len);
            step_val = int'((steps_mirror >> (STEP_W * wrapped)) & 48'hF);
            oct      = int'(shift_mirror) + dego;
            cand     = int'(root_mirror) + step_val + oct * SEMIS_PER_OCTAVE;
            if (cand < 0) cand = 0;
            else if (cand > MIDI_TOP) cand = MIDI_TOP;
            diff = (cand > target) ? cand - target : target - cand;
            if (!have || diff < best_diff || (diff == best_diff && cand < int'(r.snapped))) begin
                have      = 1'b1;
                best_diff = diff;
                r.snapped = NOTE_W'(cand);
                r.degree  = DEG_W'(d);
                r.octave  = OCT_W'(oct);
            end
        end
        return r;
    endfunction

    // Register write as the block sees it; unknown indexes change nothing
    function automatic void mirror_reg_write(input logic [CFGI_W-1:0] idx,
                                             input logic [STEPS_W-1:0] data);
        case (idx)
            CFG_ROOT_NOTE:    root_mirror  = data[NOTE_W-1:0];
            CFG_OCTAVE_SHIFT: shift_mirror = data[OCTS_W-1:0];
            CFG_SCALE_LENGTH: len_mirror   = data[LEN_W-1:0];
            CFG_SCALE_STEPS:  steps_mirror = data;
            default: ;
        endcase
    endfunction

    function automatic logic [STEPS_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic report_mismatch(input string field, input logic [NOTE_W-1:0] note,
                                   input int got, input int want);
        $display("mismatch on %s for note %0d: got %0d, want %0d at %0t",
                 field, note, got, want, $realtime);
        error_count++;
    endtask

    // One note on the input channel, after a random gap
    task automatic send_note(input logic [NOTE_W-1:0] note);
        int gap;
        gap = $urandom_range(0, 18);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_note_in <= note;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_snaps.insert(pending_snaps.size(), predict_snap(note));
    endtask

    // One register write beat; valid drops at the next falling edge
    task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [STEPS_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        mirror_reg_write(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering notes and wait until every result is back
    task automatic wait_all_snapped();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_snaps.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Result side: random stall per beat, or a requested long hold-off
    task automatic run_receiver();
        int stall;
        forever begin
            if (long_hold_cycles > 0) begin
                stall            = long_hold_cycles;
                long_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, 18);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        snap_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_snaps.size() == 0) begin
                report_mismatch("unexpected beat", m_snapped_note,
                                int'(m_snapped_note), -1);
            end else begin
                want = pending_snaps.pop_front();
                if (m_snapped_note !== want.snapped)
                    report_mismatch("snapped_note", want.note_in,
                                    int'(m_snapped_note), int'(want.snapped));
                if (m_scale_degree !== want.degree)
                    report_mismatch("scale_degree", want.note_in,
                                    int'(m_scale_degree), int'(want.degree));
                if (m_note_octave !== want.octave)
                    report_mismatch("note_octave", want.note_in,
                                    int'(m_note_octave), int'(want.octave));
            end
        end
    end

    // Reset major scale: range ends, the root, a tie between two notes
    task automatic test_reset_scale();
        send_note(7'd0);
        send_note(7'd127);
        send_note(7'd60);
        send_note(7'd66);
        send_note(7'd1);
        wait_all_snapped();
    endtask

    // Root and shift at their extremes, candidates clamped at both ends
    task automatic test_range_extremes();
        write_reg(CFG_ROOT_NOTE, 48'd0);
        write_reg(CFG_OCTAVE_SHIFT, 48'h18);       // -8
        write_reg(CFG_SCALE_LENGTH, 48'd1);
        write_reg(CFG_SCALE_STEPS, 48'd0);
        send_note(7'd0);
        send_note(7'd127);
        wait_all_snapped();
        write_reg(CFG_ROOT_NOTE, 48'd127);
        write_reg(CFG_OCTAVE_SHIFT, 48'd8);
        send_note(7'd0);
        send_note(7'd127);
        wait_all_snapped();
    endtask

    // Zero length runs as one entry, lengths above the maximum saturate
    task automatic test_length_limits();
        write_reg(CFG_ROOT_NOTE, 48'd60);
        write_reg(CFG_OCTAVE_SHIFT, 48'd0);
        write_reg(CFG_SCALE_STEPS, 48'hBA98_7654_3210);
        write_reg(CFG_SCALE_LENGTH, 48'd0);
        send_note(7'd66);
        send_note(7'd5);
        wait_all_snapped();
        write_reg(CFG_SCALE_LENGTH, 48'd13);
        send_note(7'd61);
        wait_all_snapped();
        write_reg(CFG_SCALE_LENGTH, 48'd15);
        send_note(7'd127);
        wait_all_snapped();
        write_reg(CFG_SCALE_LENGTH, 48'd12);
        send_note(7'd42);
        wait_all_snapped();
    endtask

    // Octave shift at the ends of its five-bit range
    task automatic test_shift_wide();
        write_reg(CFG_SCALE_LENGTH, 48'd7);
        write_reg(CFG_SCALE_STEPS, STEPS_RST);
        write_reg(CFG_OCTAVE_SHIFT, 48'h10);       // -16
        send_note(7'd20);
        wait_all_snapped();
        write_reg(CFG_OCTAVE_SHIFT, 48'h0F);       // +15
        send_note(7'd100);
        wait_all_snapped();
    endtask

    // Step nibbles at the top value, then all zero
    task automatic test_large_steps();
        write_reg(CFG_OCTAVE_SHIFT, 48'd0);
        write_reg(CFG_SCALE_LENGTH, 48'd12);
        write_reg(CFG_SCALE_STEPS, 48'hFFFF_FFFF_FFFF);
        send_note(7'd75);
        send_note(7'd64);
        wait_all_snapped();
        write_reg(CFG_SCALE_STEPS, 48'd0);
        send_note(7'd65);
        wait_all_snapped();
    endtask

    // Writes to unused indexes must leave every register alone
    task automatic test_unused_index();
        int idx;
        for (idx = 4; idx < 16; idx++)
            write_reg(CFGI_W'(idx), rand48());
        send_note(7'd70);
        send_note(7'd33);
        wait_all_snapped();
    endtask

    // Receiver holds off while notes keep coming, so the input stalls
    task automatic test_output_backpressure();
        write_reg(CFG_ROOT_NOTE, 48'd62);
        write_reg(CFG_SCALE_LENGTH, 48'd3);
        write_reg(CFG_SCALE_STEPS, 48'h740);
        long_hold_cycles = 400;
        repeat (6) send_note(NOTE_W'($urandom_range(0, 127)));
        wait_all_snapped();
    endtask

    // Random scales with junk in the unused data bits, random notes
    task automatic test_random_scales();
        int                 phase, i, acc, len;
        logic [STEPS_W-1:0] data;
        logic [STEPS_W-1:0] steps;
        logic [NOTE_W-1:0]  root;
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 0) root = '0;
            else if (phase == 1) root = 7'd127;
            else root = NOTE_W'($urandom_range(0, 127));
            data = rand48();
            data[NOTE_W-1:0] = root;
            write_reg(CFG_ROOT_NOTE, data);

            data = rand48();
            if ($urandom_range(0, 3) != 0)
                data[OCTS_W-1:0] = OCTS_W'($urandom_range(0, 16) - 8);
            write_reg(CFG_OCTAVE_SHIFT, data);

            // short scales are quicker and let the stalls bite
            data = rand48();
            len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
            if (phase == 2) len = 1;
            data[LEN_W-1:0] = LEN_W'(len);
            write_reg(CFG_SCALE_LENGTH, data);

            if ($urandom_range(0, 1) == 0) begin
                steps = rand48();
            end else begin
                // ascending musical scale of whole and half steps
                steps = '0;
                acc   = 0;
                for (i = 0; i < 12; i++) begin
                    steps[STEP_W*i +: STEP_W] = STEP_W'(acc);
                    acc = acc + $urandom_range(1, 2);
                    if (acc > 15) acc = 15;
                end
            end
            write_reg(CFG_SCALE_STEPS, steps);

            repeat (50) send_note(NOTE_W'($urandom_range(0, 127)));
            wait_all_snapped();
        end
    endtask

    // Sequence
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        fork
            run_receiver();
        join_none
        repeat (2) @(posedge aclk);

        test_reset_scale();
        test_range_extremes();
        test_length_limits();
        test_shift_wide();
        test_large_steps();
        test_unused_index();
        test_output_backpressure();
        test_random_scales();

        wait_all_snapped();
        repeat (250) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
